[hdl/led_matrix_frame_store_macros.svh]
// assertion macros shared by the led matrix frame store rtl
`ifndef LED_MATRIX_FRAME_STORE_MACROS_SVH
`define LED_MATRIX_FRAME_STORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LMFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LMFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lmfs_pkg.sv]
// package with types, constants and helpers of the led matrix frame store
`default_nettype none

package lmfs_pkg;

   // frame geometry
   localparam int PAGES       = 4;
   localparam int ROWS        = 7;
   localparam int COLUMNS     = 32;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int LINE_W      = PAGES * 8;
   localparam int GLYPH_SLOTS = 6;

   // show walks five address groups of ROWS lines each
   localparam int SHOW_GROUPS = 5;
   localparam int GROUP_W     = $clog2(SHOW_GROUPS);

   // packed channel widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;

   // operation codes
   typedef enum logic [2:0] {
      OP_SET_PIXEL  = 3'd0,
      OP_WRITE_BITS = 3'd1,
      OP_GLYPH_ROW  = 3'd2,
      OP_CLEAR      = 3'd3,
      OP_SHOW       = 3'd4
   } op_type;

   // control states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // show group codes
   localparam logic [GROUP_W-1:0] GRP_PAGE0   = 3'd0;
   localparam logic [GROUP_W-1:0] GRP_PAGE1   = 3'd1;
   localparam logic [GROUP_W-1:0] GRP_PAGE2LO = 3'd2;
   localparam logic [GROUP_W-1:0] GRP_MIXED   = 3'd3;
   localparam logic [GROUP_W-1:0] GRP_PAGE3HI = 3'd4;

   // first bit of a glyph slot inside the 32-bit line
   function automatic logic [4:0] glyph_offset(input logic [2:0] slot);
      logic [4:0] off;
      begin
         unique case (slot)
            3'd0:    off = 5'd0;
            3'd1:    off = 5'd5;
            3'd2:    off = 5'd12;
            3'd3:    off = 5'd17;
            3'd4:    off = 5'd22;
            3'd5:    off = 5'd27;
            default: off = 5'd0;
         endcase
         return off;
      end
   endfunction

   // driver address of line 0 for a show group
   function automatic logic [7:0] group_base(input logic [GROUP_W-1:0] grp);
      logic [7:0] base;
      begin
         unique case (grp)
            GRP_PAGE0:   base = 8'hC0;
            GRP_PAGE1:   base = 8'hC1;
            GRP_PAGE2LO: base = 8'hC2;
            GRP_MIXED:   base = 8'hDC;
            GRP_PAGE3HI: base = 8'hDD;
            default:     base = 8'h00;
         endcase
         return base;
      end
   endfunction

endpackage

`default_nettype wire

[hdl/led_matrix_frame_store.sv]
// led matrix frame store: 32x7 frame with pixel, bit, glyph, clear and show operations
//
// Input channel req_*: one operation per transfer, op in req_tuser, operands in req_tdata.
// Result channel rsp_*: ok in rsp_tuser, driver address and data in rsp_tdata, rsp_tlast
// marks the final result of an operation.
// The frame is a row memory of 7 entries of 32 bits (one entry per pixel row, four pages
// side by side), read through a registered port and written back by the same control.
// Set pixel, write bits, glyph row, clear and rejected operations: one result; an item is
// accepted, then the read-modify-write step loads the result register once it is free.
// Show: 35 results after the accept, one per cycle while the receiver does not stall.
// The result register decouples the two sides: a new item is accepted as soon as control is
// idle, even while the last result still waits for rsp_tready.
// When the receiver stalls, the next result waits inside the block and no memory update
// commits until the result register can take it.
// Reset clears the control state and the per-row valid bits; a row that is not valid reads
// as blank, so the frame is all dark right after reset with no clearing pass. Clear also
// drops all valid bits at once.
`default_nettype none

`include "led_matrix_frame_store_macros.svh"

module led_matrix_frame_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: x_pos[5:0], row[8:6], pixel_on[9], page[12:10], bits[20:13],
   //            low_bit[23:21], high_bit[26:24], glyph_slot[29:27], glyph_bits[34:30]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [lmfs_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: op[2:0]
   input  wire logic [lmfs_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rsp_tdata: chip_address[7:0], chip_data[15:8]
   output logic      [lmfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: ok
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   import lmfs_pkg::*;

   localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [GROUP_W-1:0] GROUP_LAST = GROUP_W'(SHOW_GROUPS - 1);

   // control and operand registers
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [5:0]         x_ff, x_in;
   logic [ROW_W-1:0]   line_ff, line_in;
   logic               on_ff, on_in;
   logic [2:0]         page_ff, page_in;
   logic [7:0]         bits_ff, bits_in;
   logic [2:0]         lo_ff, lo_in;
   logic [2:0]         hi_ff, hi_in;
   logic [2:0]         slot_ff, slot_in;
   logic [4:0]         glyph_ff, glyph_in;
   logic [GROUP_W-1:0] grp_ff, grp_in;
   logic [ROWS-1:0]    valid_ff, valid_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [7:0]         rsp_addr_ff, rsp_addr_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;

   // memory ports
   logic               ram_wr_en;
   logic [ROW_W-1:0]   ram_rd_addr_raw;
   logic [ROW_W-1:0]   ram_rd_addr;
   logic [LINE_W-1:0]  ram_rd_data;
   logic [LINE_W-1:0]  new_line;

   // datapath signals
   op_type             req_op;
   logic               row_ok;
   logic               op_ok;
   logic               op_writes;
   logic [LINE_W-1:0]  line_data;
   logic [7:0]         range_mask;
   logic [LINE_W-1:0]  upd_mask;
   logic [LINE_W-1:0]  upd_data;
   logic [7:0]         show_byte;
   logic [7:0]         show_addr;
   logic               show_end;
   logic [ROW_W-1:0]   line_nxt;
   logic               out_free;

   assign req_op   = op_type'(req_tuser[2:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // row memory, one 32-bit entry per pixel row
   lmfs_ram #(
      .WIDTH (LINE_W),
      .DEPTH (ROWS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (line_ff),
      .wr_data (new_line),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // keep the read address inside the memory for rejected rows
   assign ram_rd_addr = (ram_rd_addr_raw <= ROW_LAST) ? ram_rd_addr_raw : '0;

   // a row never written since reset or clear reads as blank
   assign row_ok    = (line_ff <= ROW_LAST);
   assign line_data = (row_ok && valid_ff[line_ff]) ? ram_rd_data : '0;

   // operand checks
   always_comb begin
      op_ok     = 1'b0;
      op_writes = 1'b0;
      unique case (op_ff)
         OP_SET_PIXEL: begin
            op_ok     = (x_ff < 6'(COLUMNS)) && row_ok;
            op_writes = 1'b1;
         end
         OP_WRITE_BITS: begin
            op_ok     = (page_ff < 3'(PAGES)) && row_ok && (lo_ff <= hi_ff);
            op_writes = 1'b1;
         end
         OP_GLYPH_ROW: begin
            op_ok     = (slot_ff < 3'(GLYPH_SLOTS)) && row_ok;
            op_writes = 1'b1;
         end
         OP_CLEAR: op_ok = 1'b1;
         OP_SHOW:  op_ok = 1'b1;
         default:  op_ok = 1'b0;
      endcase
   end

   // update mask and data for the row being modified
   assign range_mask = (8'hFF << lo_ff) & (8'hFF >> (3'd7 - hi_ff));

   always_comb begin
      upd_mask = '0;
      upd_data = '0;
      unique case (op_ff)
         OP_SET_PIXEL: begin
            upd_mask = LINE_W'(1) << x_ff[4:0];
            upd_data = on_ff ? upd_mask : '0;
         end
         OP_WRITE_BITS: begin
            upd_mask = LINE_W'(range_mask) << {page_ff[1:0], 3'b000};
            upd_data = LINE_W'(bits_ff) << {page_ff[1:0], 3'b000};
         end
         OP_GLYPH_ROW: begin
            upd_mask = LINE_W'(5'h1F) << glyph_offset(slot_ff);
            upd_data = LINE_W'(glyph_ff) << glyph_offset(slot_ff);
         end
         default: begin
            upd_mask = '0;
            upd_data = '0;
         end
      endcase
   end

   assign new_line = (line_data & ~upd_mask) | (upd_data & upd_mask);

   // driver byte for the current show group and line
   always_comb begin
      unique case (grp_ff)
         GRP_PAGE0:   show_byte = line_data[7:0];
         GRP_PAGE1:   show_byte = line_data[15:8];
         GRP_PAGE2LO: show_byte = {7'd0, line_data[16]};
         GRP_MIXED:   show_byte = {line_data[24], line_data[23:17]};
         GRP_PAGE3HI: show_byte = {1'b0, line_data[31:25]};
         default:     show_byte = 8'd0;
      endcase
   end

   assign show_addr = group_base(grp_ff) + {{(8 - ROW_W - 2){1'b0}}, line_ff, 2'b00};
   assign show_end  = (grp_ff == GROUP_LAST) && (line_ff == ROW_LAST);
   assign line_nxt  = (line_ff == ROW_LAST) ? '0 : line_ff + 1'b1;

   // handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_byte_ff, rsp_addr_ff};

   // next state, memory control and result loading
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      x_in            = x_ff;
      line_in         = line_ff;
      on_in           = on_ff;
      page_in         = page_ff;
      bits_in         = bits_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      slot_in         = slot_ff;
      glyph_in        = glyph_ff;
      grp_in          = grp_ff;
      valid_in        = valid_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_ok_in       = rsp_ok_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_byte_in     = rsp_byte_ff;
      ram_wr_en       = 1'b0;
      ram_rd_addr_raw = line_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_addr_raw = (req_op == OP_SHOW) ? '0 : req_tdata[8:6];
            if (req_tvalid) begin
               op_in    = req_op;
               x_in     = req_tdata[5:0];
               line_in  = (req_op == OP_SHOW) ? '0 : req_tdata[8:6];
               on_in    = req_tdata[9];
               page_in  = req_tdata[12:10];
               bits_in  = req_tdata[20:13];
               lo_in    = req_tdata[23:21];
               hi_in    = req_tdata[26:24];
               slot_in  = req_tdata[29:27];
               glyph_in = req_tdata[34:30];
               grp_in   = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = op_ok;
               if (op_ff == OP_SHOW) begin
                  rsp_addr_in     = show_addr;
                  rsp_byte_in     = show_byte;
                  rsp_last_in     = show_end;
                  line_in         = line_nxt;
                  ram_rd_addr_raw = line_nxt;
                  if (line_ff == ROW_LAST) begin
                     grp_in = grp_ff + 1'b1;
                  end
                  if (show_end) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_addr_in = 8'd0;
                  rsp_byte_in = 8'd0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
                  if (op_ok && op_writes) begin
                     ram_wr_en         = 1'b1;
                     valid_in[line_ff] = 1'b1;
                  end
                  if (op_ff == OP_CLEAR) begin
                     valid_in = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand and result payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      x_ff        <= x_in;
      line_ff     <= line_in;
      on_ff       <= on_in;
      page_ff     <= page_in;
      bits_ff     <= bits_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      slot_ff     <= slot_in;
      glyph_ff    <= glyph_in;
      grp_ff      <= grp_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // checks on the control and datapath
   `LMFS_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_tvalid && req_tready, state_ff == ST_EXEC, "accepted transfer did not start execution")
   `LMFS_ASSERT_SAME(a_write_only_ok, clock, reset, ram_wr_en, op_ok && row_ok && out_free, "row memory written for a rejected or stalled operation")
   `LMFS_ASSERT_NEXT(a_clear_drops_rows, clock, reset, state_ff == ST_EXEC && op_ff == OP_CLEAR && out_free, valid_ff == '0, "clear left a row marked valid")
   `LMFS_ASSERT_SAME(a_reject_no_data, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_tdata == '0 && rsp_last_ff, "rejected result carries driver data")
   `LMFS_ASSERT_SAME(a_show_in_range, clock, reset, state_ff == ST_EXEC && op_ff == OP_SHOW, grp_ff <= GROUP_LAST && line_ff <= ROW_LAST, "show walk left its range")

endmodule

`default_nettype wire

[hdl/lmfs_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module lmfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[tb/led_matrix_frame_store_checker.sv]
// checker for the led matrix frame store: predicts driver words and compares result transfers
`default_nettype none

module led_matrix_frame_store_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // req_tdata: x_pos, row, pixel_on, page, bits, low_bit, high_bit, glyph_slot, glyph_bits
   input  wire logic [lmfs_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: op
   input  wire logic [lmfs_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rsp_tdata: chip_address, chip_data
   input  wire logic [lmfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: ok
   input  wire logic                            rsp_tuser,
   input  wire logic                            rsp_tlast,
   output int                                   mismatch_count,
   output int                                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import lmfs_pkg::*;

   // operand layout of req_tdata, highest field first
   typedef struct packed {
      logic [4:0] spare;
      logic [4:0] glyph_bits;
      logic [2:0] glyph_slot;
      logic [2:0] high_bit;
      logic [2:0] low_bit;
      logic [7:0] bits;
      logic [2:0] page;
      logic       pixel_on;
      logic [2:0] row;
      logic [5:0] x_pos;
   } operands_type;

   typedef struct {
      logic       ok;
      logic [7:0] chip_address;
      logic [7:0] chip_data;
      logic       last;
   } driver_word_type;

   // predicted frame, indexed by page then row
   logic [7:0]      frame_bytes [PAGES][ROWS];
   driver_word_type expected_words [$];
   driver_word_type want;
   int              fails = 0;
   int              waiting = 0;

   assign mismatch_count = fails;
   assign outstanding    = waiting;

   initial begin
      for (int p = 0; p < PAGES; p++)
         for (int r = 0; r < ROWS; r++)
            frame_bytes[p][r] = 8'h00;
   end

   task automatic push_word(input logic ok, input logic [7:0] addr, input logic [7:0] data,
                            input logic last);
      driver_word_type w;
      w.ok           = ok;
      w.chip_address = addr;
      w.chip_data    = data;
      w.last         = last;
      expected_words.push_back(w);
   endtask

   // apply one operation to the predicted frame and queue the driver words it yields
   task automatic predict_frame_op(input logic [2:0] op, input operands_type f);
      logic        accepted;
      logic [7:0]  mask;
      logic [31:0] line;
      int          lsb;
      logic [7:0]  addr;
      logic [7:0]  data;
      accepted = 1'b0;
      case (op)
         OP_SET_PIXEL: begin
            if (f.x_pos < COLUMNS && f.row < ROWS) begin
               frame_bytes[f.x_pos[4:3]][f.row][f.x_pos[2:0]] = f.pixel_on;
               accepted = 1'b1;
            end
         end
         OP_WRITE_BITS: begin
            if (f.page < PAGES && f.row < ROWS && f.low_bit <= f.high_bit) begin
               mask = 8'h00;
               for (int b = 0; b < 8; b++)
                  if (b >= f.low_bit && b <= f.high_bit) mask[b] = 1'b1;
               frame_bytes[f.page][f.row] = (frame_bytes[f.page][f.row] & ~mask) |
                                            (f.bits & mask);
               accepted = 1'b1;
            end
         end
         OP_GLYPH_ROW: begin
            if (f.glyph_slot < GLYPH_SLOTS && f.row < ROWS) begin
               // slots sit at fixed bit positions of the 32-pixel line, 10 and 11 unused
               case (f.glyph_slot)
                  3'd0:    lsb = 0;
                  3'd1:    lsb = 5;
                  3'd2:    lsb = 12;
                  3'd3:    lsb = 17;
                  3'd4:    lsb = 22;
                  default: lsb = 27;
               endcase
               line = {frame_bytes[3][f.row], frame_bytes[2][f.row],
                       frame_bytes[1][f.row], frame_bytes[0][f.row]};
               line[lsb +: 5] = f.glyph_bits;
               {frame_bytes[3][f.row], frame_bytes[2][f.row],
                frame_bytes[1][f.row], frame_bytes[0][f.row]} = line;
               accepted = 1'b1;
            end
         end
         OP_CLEAR: begin
            for (int p = 0; p < PAGES; p++)
               for (int r = 0; r < ROWS; r++)
                  frame_bytes[p][r] = 8'h00;
            accepted = 1'b1;
         end
         OP_SHOW: begin
            // five address groups, seven lines each, pages 2 and 3 repacked
            for (int grp = 0; grp < SHOW_GROUPS; grp++)
               for (int ln = 0; ln < ROWS; ln++) begin
                  case (grp)
                     GRP_PAGE0: begin
                        addr = 8'hC0;
                        data = frame_bytes[0][ln];
                     end
                     GRP_PAGE1: begin
                        addr = 8'hC1;
                        data = frame_bytes[1][ln];
                     end
                     GRP_PAGE2LO: begin
                        addr = 8'hC2;
                        data = {7'b0, frame_bytes[2][ln][0]};
                     end
                     GRP_MIXED: begin
                        addr = 8'hDC;
                        data = {frame_bytes[3][ln][0], frame_bytes[2][ln][7:1]};
                     end
                     default: begin
                        addr = 8'hDD;
                        data = {1'b0, frame_bytes[3][ln][7:1]};
                     end
                  endcase
                  push_word(1'b1, addr + 8'(4 * ln), data,
                            grp == GRP_PAGE3HI && ln == ROWS - 1);
               end
         end
         default: accepted = 1'b0;
      endcase
      if (op != OP_SHOW) push_word(accepted, 8'h00, 8'h00, 1'b1);
   endtask

   // watch both channels; operations first, results after
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_frame_op(req_tuser, operands_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result ok=%0d addr=%02h data=%02h last=%0d", $time,
                        rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
               fails++;
            end else begin
               want = expected_words.pop_front();
               if (want.ok !== rsp_tuser || want.chip_address !== rsp_tdata[7:0] ||
                   want.chip_data !== rsp_tdata[15:8] || want.last !== rsp_tlast) begin
                  $display("%0t: mismatch expected ok=%0d addr=%02h data=%02h last=%0d, %s",
                           $time, want.ok, want.chip_address, want.chip_data, want.last,
                           "actual below");
                  $display("%0t:          actual   ok=%0d addr=%02h data=%02h last=%0d",
                           $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
                  fails++;
               end
            end
         end
         waiting = expected_words.size();
      end
   end

endmodule

`default_nettype wire

[tb/led_matrix_frame_store_tb.sv]
// testbench top for the led matrix frame store: stimulus, pacing and verdict
`default_nettype none

module led_matrix_frame_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmfs_pkg::*;

   localparam int         CYCLE_LIMIT       = 500000;
   localparam int         SETTLE_CYCLES     = 50;
   localparam int         RANDOM_PER_PHASE  = 63;
   localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

   // pacing of the two channels
   typedef enum int {
      PACE_FREE,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   // operand layout of req_tdata, highest field first
   typedef struct packed {
      logic [4:0] spare;
      logic [4:0] glyph_bits;
      logic [2:0] glyph_slot;
      logic [2:0] high_bit;
      logic [2:0] low_bit;
      logic [7:0] bits;
      logic [2:0] page;
      logic       pixel_on;
      logic [2:0] row;
      logic [5:0] x_pos;
   } operands_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // req_tdata: x_pos, row, pixel_on, page, bits, low_bit, high_bit, glyph_slot, glyph_bits
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // req_tuser: op
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // rsp_tdata: chip_address, chip_data
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // rsp_tuser: ok
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   int                    mismatch_count;
   int                    outstanding;
   int                    cycle_count = 0;
   pace_type              pace = PACE_FREE;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   led_matrix_frame_store u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   led_matrix_frame_store_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // receiver stalls by pacing phase
   always @(posedge clock) begin
      case (pace)
         PACE_RECEIVER_STALL: rsp_tready <= ($urandom_range(0, 99) >= 84);
         PACE_BOTH:           rsp_tready <= ($urandom_range(0, 99) >= 9);
         default:             rsp_tready <= 1'b1;
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("led_matrix_frame_store regression: fail");
         $finish;
      end
   end

   // random fill for every field, padding kept zero
   function automatic operands_type noise_operands();
      logic [63:0]  r;
      operands_type f;
      r       = {$urandom(), $urandom()};
      f       = r[REQ_DATA_W-1:0];
      f.spare = '0;
      return f;
   endfunction

   // one operation transfer, with sender gaps by pacing phase
   task automatic send_item(input logic [2:0] op, input operands_type f);
      int idle_pct;
      idle_pct = (pace == PACE_SENDER_IDLE) ? 84 : (pace == PACE_BOTH) ? 9 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= f;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [5:0] x, input logic [2:0] row, input logic on);
      operands_type f;
      f          = noise_operands();
      f.x_pos    = x;
      f.row      = row;
      f.pixel_on = on;
      send_item(OP_SET_PIXEL, f);
   endtask

   task automatic send_bits(input logic [2:0] page, input logic [2:0] row,
                            input logic [7:0] bits, input logic [2:0] lo, input logic [2:0] hi);
      operands_type f;
      f          = noise_operands();
      f.page     = page;
      f.row      = row;
      f.bits     = bits;
      f.low_bit  = lo;
      f.high_bit = hi;
      send_item(OP_WRITE_BITS, f);
   endtask

   task automatic send_glyph(input logic [2:0] slot, input logic [2:0] row,
                             input logic [4:0] glyph);
      operands_type f;
      f            = noise_operands();
      f.glyph_slot = slot;
      f.row        = row;
      f.glyph_bits = glyph;
      send_item(OP_GLYPH_ROW, f);
   endtask

   // mostly well-formed operations with random content, some rejected or unknown
   task automatic send_random_item();
      operands_type f;
      int           pick;
      logic         well_formed;
      logic [2:0]   op;
      f           = noise_operands();
      pick        = $urandom_range(0, 99);
      well_formed = ($urandom_range(0, 99) < 85);
      if (pick < 32) begin
         op = OP_SET_PIXEL;
         if (well_formed) begin
            f.x_pos = 6'($urandom_range(0, COLUMNS - 1));
            f.row   = 3'($urandom_range(0, ROWS - 1));
         end
      end else if (pick < 60) begin
         op = OP_WRITE_BITS;
         if (well_formed) begin
            f.page     = 3'($urandom_range(0, PAGES - 1));
            f.row      = 3'($urandom_range(0, ROWS - 1));
            f.low_bit  = 3'($urandom_range(0, 7));
            f.high_bit = 3'($urandom_range(f.low_bit, 7));
         end
      end else if (pick < 86) begin
         op = OP_GLYPH_ROW;
         if (well_formed) begin
            f.glyph_slot = 3'($urandom_range(0, GLYPH_SLOTS - 1));
            f.row        = 3'($urandom_range(0, ROWS - 1));
         end
      end else if (pick < 94) begin
         op = OP_SHOW;
      end else if (pick < 96) begin
         op = OP_CLEAR;
      end else begin
         op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
      end
      send_item(op, f);
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // pixel corners, off, and out-of-range coordinates
      send_pixel(6'd0, 3'd0, 1'b1);
      send_pixel(6'd31, 3'd6, 1'b1);
      send_pixel(6'd63, 3'd0, 1'b1);
      send_pixel(6'd5, 3'd7, 1'b1);
      send_pixel(6'd0, 3'd0, 1'b0);

      // full and partial masked writes, bad page, bad row, inverted range
      send_bits(3'd0, 3'd0, 8'hFF, 3'd0, 3'd7);
      send_bits(3'd3, 3'd6, 8'hA5, 3'd2, 3'd5);
      send_bits(3'd7, 3'd1, 8'hFF, 3'd0, 3'd7);
      send_bits(3'd1, 3'd7, 8'hFF, 3'd0, 3'd7);
      send_bits(3'd2, 3'd3, 8'hFF, 3'd5, 3'd2);

      // every glyph slot, then bad slot and bad row
      for (int s = 0; s < GLYPH_SLOTS; s++)
         send_glyph(3'(s), 3'(s), (s % 2 == 0) ? 5'h1F : 5'h0A);
      send_glyph(3'd7, 3'd0, 5'h1F);
      send_glyph(3'd0, 3'd7, 5'h1F);

      // show, unknown codes, clear, show again
      send_item(OP_SHOW, noise_operands());
      send_item(OP_RESERVED_FIRST, noise_operands());
      send_item(OP_RESERVED_LAST, noise_operands());
      send_item(OP_CLEAR, noise_operands());
      send_item(OP_SHOW, noise_operands());

      // random phases, each entered with the pipeline empty
      for (int ph = 0; ph < 4; ph++) begin
         wait_until_drained();
         pace <= pace_type'(ph);
         repeat (RANDOM_PER_PHASE) send_random_item();
      end
      send_item(OP_SHOW, noise_operands());

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("led_matrix_frame_store regression: pass");
      end else begin
         $display("led_matrix_frame_store regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/lmfs_pkg.sv
hdl/lmfs_ram.sv
hdl/led_matrix_frame_store.sv
tb/led_matrix_frame_store_checker.sv
tb/led_matrix_frame_store_tb.sv
